// ----- rtl/fcr_pkg.sv -----
// Shared constants and types for the character-rain engine.
`timescale 1ns / 1ps
package fcr_pkg;
   localparam int NUM_DROPS   = 28;
   localparam int SCREEN_COLS = 32;
   localparam int SCREEN_ROWS = 16;
   localparam int DROP_W      = $clog2(NUM_DROPS);
   localparam int ADDR_W      = 9;
   localparam int POS_W       = 12;

   localparam logic signed [POS_W-1:0] SCREEN_CELLS   = POS_W'(SCREEN_COLS * SCREEN_ROWS);
   localparam logic signed [POS_W-1:0] LAST_ROW_START = POS_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
   localparam logic signed [POS_W-1:0] START_ABOVE    = -12'sd256;
   localparam logic [31:0] ABOVE_PATTERN = 32'h4105_5555;

   localparam logic [7:0]  CELL_EMPTY   = 8'h80;
   localparam logic [7:0]  HIGHLIGHT    = 8'h40;
   localparam logic [7:0]  LETTER_MASK  = 8'h3f;
   localparam logic [7:0]  LETTER_SPACE = 8'h20;
   localparam logic [7:0]  LETTER_BANG  = 8'h21;
   localparam logic [7:0]  BLOCK_BASE   = 8'h80;
   localparam logic [7:0]  BLOCK_SOLID  = 8'h8f;
   localparam logic [7:0]  FEEDBACK     = 8'hb4;
   localparam logic [15:0] LFSR_SEED    = 16'h1c15;

   localparam logic [1:0] FUNC_INIT  = 2'd0;
   localparam logic [1:0] FUNC_FRAME = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [2:0] REG_GLITCH  = 3'd0;
   localparam logic [2:0] REG_REVERSE = 3'd1;
   localparam logic [2:0] REG_NEWCHAR = 3'd2;
   localparam logic [2:0] REG_GRAPHIC = 3'd3;
   localparam logic [2:0] REG_TMIN    = 3'd4;
   localparam logic [2:0] REG_TMAX    = 3'd5;
   localparam logic [2:0] REG_SSTART  = 3'd6;
   localparam logic [2:0] REG_SRESET  = 3'd7;

   typedef struct packed {
      logic [7:0] glitch_chance;
      logic [7:0] reverse_chance;
      logic [7:0] newchar_chance;
      logic [7:0] graphic_chance;
      logic [4:0] trail_min;
      logic [4:0] trail_max;
      logic [5:0] speed_start;
      logic [5:0] speed_reset;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic       done;
      logic       op_done;
      logic [7:0] value;
   } seq_rsp_type;
endpackage

// ----- rtl/fcr_lfsr.sv -----
// 16-bit LFSR draw unit, one byte per step.
`timescale 1ns / 1ps
module fcr_lfsr (
   input  logic       clock,
   input  logic       reset,
   input  logic       seed,
   input  logic       step,
   output logic [7:0] draw
);
   import fcr_pkg::*;

   logic [15:0] lfsr_ff, lfsr_in;
   logic [7:0]  lo, hi;

   always_comb begin
      lo = {lfsr_ff[6:0], lfsr_ff[8]};
      hi = {1'b0, lfsr_ff[15:9]} ^ (lfsr_ff[7] ? FEEDBACK : 8'h00);
      draw = hi ^ lo;
      lfsr_in = lfsr_ff;
      if (seed) begin
         lfsr_in = LFSR_SEED;
      end else if (step) begin
         lfsr_in = {hi, lo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end
endmodule

// ----- rtl/fcr_screen_ram.sv -----
// 512-byte screen store, one access per cycle, registered read.
`timescale 1ns / 1ps
module fcr_screen_ram (
   input  logic                clock,
   input  fcr_pkg::mem_req_type req,
   output logic [7:0]          rdata
);
   import fcr_pkg::*;

   logic [7:0] mem_ff [2**ADDR_W];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.addr] <= req.wdata;
      end
      rdata_ff <= mem_ff[req.addr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/fcr_seq.sv -----
// Sequencer: init, frame walk over the drops and cell read.
`timescale 1ns / 1ps
module fcr_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  fcr_pkg::cfg_type     cfg,
   input  logic                 start,
   input  logic [1:0]           func,
   input  logic [8:0]           cell_address,
   input  logic                 rsp_free,
   output logic                 busy,
   output fcr_pkg::seq_rsp_type rsp
);
   import fcr_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CLR   = 5'd1;
   localparam logic [4:0] S_ISPD  = 5'd2;
   localparam logic [4:0] S_ITRL  = 5'd3;
   localparam logic [4:0] S_DROP  = 5'd4;
   localparam logic [4:0] S_NCH   = 5'd5;
   localparam logic [4:0] S_CHKH  = 5'd6;
   localparam logic [4:0] S_NCG   = 5'd7;
   localparam logic [4:0] S_NCC   = 5'd8;
   localparam logic [4:0] S_NHR   = 5'd9;
   localparam logic [4:0] S_WRH   = 5'd10;
   localparam logic [4:0] S_RDA   = 5'd11;
   localparam logic [4:0] S_WRA   = 5'd12;
   localparam logic [4:0] S_GL    = 5'd13;
   localparam logic [4:0] S_GR    = 5'd14;
   localparam logic [4:0] S_MOVE  = 5'd15;
   localparam logic [4:0] S_RPOS  = 5'd16;
   localparam logic [4:0] S_RSPD  = 5'd17;
   localparam logic [4:0] S_RTRL  = 5'd18;
   localparam logic [4:0] S_RD    = 5'd19;
   localparam logic [4:0] S_RDCAP = 5'd20;
   localparam logic [4:0] S_DONE  = 5'd21;

   logic [4:0]  state_ff, state_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [DROP_W-1:0] d_ff, d_in;
   logic signed [POS_W-1:0] p_ff, p_in;
   logic signed [POS_W-1:0] oth_ff, oth_in;
   logic [7:0]  ch_ff, ch_in;
   logic        gfx_ff, gfx_in;
   logic        ret_glitch_ff, ret_glitch_in;
   logic        reply_ff, reply_in;
   logic [1:0]  func_ff, func_in;
   logic [8:0]  addr_ff, addr_in;
   logic [7:0]  value_ff, value_in;

   logic signed [POS_W-1:0] drop_pos_ff [NUM_DROPS];
   logic [4:0] drop_speed_ff [NUM_DROPS];
   logic [4:0] drop_wait_ff  [NUM_DROPS];
   logic [4:0] drop_trail_ff [NUM_DROPS];
   logic        pos_we, speed_we, wait_we, trail_we;
   logic signed [POS_W-1:0] pos_in;
   logic [4:0]  speed_in, wait_in, trail_in;

   logic        seed, step;
   logic [7:0]  draw;
   mem_req_type mreq;
   logic [7:0]  rdata;

   logic [4:0]  t;
   logic [5:0]  lim_s, lim_r, tr_n;
   logic [4:0]  tr_hi;
   logic signed [POS_W-1:0] p_up, p_tail, p_gl;
   logic [3:0]  row;
   logic [7:0]  nc;
   logic        last_drop;

   function automatic logic in_view(input logic signed [POS_W-1:0] x);
      in_view = (x >= 0) && (x < SCREEN_CELLS);
   endfunction

   function automatic logic [5:0] clamp_lim(input logic [5:0] v);
      if (v == 6'd0) begin
         clamp_lim = 6'd1;
      end else if (v > 6'd32) begin
         clamp_lim = 6'd32;
      end else begin
         clamp_lim = v;
      end
   endfunction

   fcr_lfsr u_lfsr (.clock(clock), .reset(reset), .seed(seed), .step(step), .draw(draw));
   fcr_screen_ram u_ram (.clock(clock), .req(mreq), .rdata(rdata));

   always_comb begin
      t      = drop_trail_ff[d_ff];
      lim_s  = clamp_lim(cfg.speed_start);
      lim_r  = clamp_lim(cfg.speed_reset);
      tr_hi  = (cfg.trail_max < cfg.trail_min) ? cfg.trail_min : cfg.trail_max;
      tr_n   = {1'b0, draw[4:0]} + {1'b0, cfg.trail_min};
      p_up   = p_ff - POS_W'(SCREEN_COLS);
      p_tail = p_ff - signed'({2'b00, t, 5'b0});
      row    = draw[3:0];
      p_gl   = p_ff - signed'({3'b000, row, 5'b0});
      if (gfx_ff) begin
         nc = BLOCK_BASE | (draw & 8'h0f);
         if (nc == BLOCK_BASE) nc = BLOCK_SOLID;
      end else begin
         nc = draw & LETTER_MASK;
         if (nc == LETTER_SPACE) nc = LETTER_BANG;
      end
      last_drop = (d_ff == DROP_W'(NUM_DROPS - 1));

      state_in = state_ff;
      cnt_in = cnt_ff;
      d_in = d_ff;
      p_in = p_ff;
      oth_in = oth_ff;
      ch_in = ch_ff;
      gfx_in = gfx_ff;
      ret_glitch_in = ret_glitch_ff;
      reply_in = reply_ff;
      func_in = func_ff;
      addr_in = addr_ff;
      value_in = value_ff;
      pos_we = 1'b0;
      speed_we = 1'b0;
      wait_we = 1'b0;
      trail_we = 1'b0;
      pos_in = p_ff + POS_W'(SCREEN_COLS);
      speed_in = draw[4:0];
      wait_in = 5'd0;
      trail_in = tr_n[4:0];
      seed = 1'b0;
      step = 1'b0;
      mreq.we = 1'b0;
      mreq.addr = p_ff[ADDR_W-1:0];
      mreq.wdata = CELL_EMPTY;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = func;
               addr_in = cell_address;
               value_in = 8'h00;
               reply_in = 1'b1;
               d_in = '0;
               cnt_in = '0;
               case (func)
                  FUNC_INIT: begin
                     seed = 1'b1;
                     state_in = S_CLR;
                  end
                  FUNC_FRAME: state_in = S_DROP;
                  FUNC_READ:  state_in = S_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            mreq.we = 1'b1;
            mreq.addr = cnt_ff;
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'h1ff) state_in = S_ISPD;
         end
         S_ISPD: begin
            step = 1'b1;
            if ({1'b0, draw[4:0]} < lim_s) begin
               speed_we = 1'b1;
               state_in = S_ITRL;
            end
         end
         S_ITRL: begin
            step = 1'b1;
            if (tr_n <= {1'b0, tr_hi}) begin
               trail_we = 1'b1;
               wait_we = 1'b1;
               pos_we = 1'b1;
               pos_in = signed'(POS_W'(d_ff)) + (ABOVE_PATTERN[d_ff] ? START_ABOVE : '0);
               d_in = d_ff + 1'b1;
               state_in = last_drop ? S_DONE : S_ISPD;
            end
         end
         S_DROP: begin
            p_in = drop_pos_ff[d_ff];
            state_in = in_view(drop_pos_ff[d_ff]) ? S_NCH : S_MOVE;
         end
         S_NCH: begin
            step = 1'b1;
            ret_glitch_in = 1'b0;
            state_in = (draw < cfg.newchar_chance) ? S_NCG : S_CHKH;
         end
         S_CHKH: begin
            ch_in = rdata;
            state_in = (rdata == CELL_EMPTY) ? S_NCG : S_WRH;
         end
         S_NCG: begin
            step = 1'b1;
            gfx_in = draw < cfg.graphic_chance;
            state_in = S_NCC;
         end
         S_NCC: begin
            step = 1'b1;
            ch_in = nc;
            if (ret_glitch_ff) begin
               mreq.we = 1'b1;
               mreq.addr = oth_ff[ADDR_W-1:0];
               mreq.wdata = nc;
               state_in = S_MOVE;
            end else begin
               state_in = S_NHR;
            end
         end
         S_NHR: begin
            step = 1'b1;
            if (draw < cfg.reverse_chance) ch_in = ch_ff | HIGHLIGHT;
            state_in = S_WRH;
         end
         S_WRH: begin
            mreq.we = 1'b1;
            mreq.wdata = (p_ff >= LAST_ROW_START) ? (ch_ff & ~HIGHLIGHT) : ch_ff;
            state_in = in_view(p_up) ? S_RDA : S_MOVE;
         end
         S_RDA: begin
            mreq.addr = p_up[ADDR_W-1:0];
            state_in = S_WRA;
         end
         S_WRA: begin
            mreq.we = 1'b1;
            mreq.addr = p_up[ADDR_W-1:0];
            mreq.wdata = rdata & ~HIGHLIGHT;
            state_in = S_GL;
         end
         S_GL: begin
            step = 1'b1;
            state_in = (draw < cfg.glitch_chance) ? S_GR : S_MOVE;
         end
         S_GR: begin
            step = 1'b1;
            oth_in = p_gl;
            ret_glitch_in = 1'b1;
            if (row != 4'd0 && {1'b0, row} < t && in_view(p_gl)) begin
               state_in = S_NCG;
            end else begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            wait_we = 1'b1;
            if (drop_wait_ff[d_ff] != drop_speed_ff[d_ff]) begin
               wait_in = drop_wait_ff[d_ff] + 5'd1;
               d_in = d_ff + 1'b1;
               state_in = last_drop ? S_DONE : S_DROP;
            end else if (p_tail >= SCREEN_CELLS) begin
               state_in = S_RPOS;
            end else begin
               if (p_tail >= 0) begin
                  mreq.we = 1'b1;
                  mreq.addr = p_tail[ADDR_W-1:0];
               end
               pos_we = 1'b1;
               d_in = d_ff + 1'b1;
               state_in = last_drop ? S_DONE : S_DROP;
            end
         end
         S_RPOS: begin
            step = 1'b1;
            pos_we = 1'b1;
            pos_in = signed'(POS_W'(draw[4:0]));
            state_in = S_RSPD;
         end
         S_RSPD: begin
            step = 1'b1;
            if ({1'b0, draw[4:0]} < lim_r) begin
               speed_we = 1'b1;
               state_in = S_RTRL;
            end
         end
         S_RTRL: begin
            step = 1'b1;
            if (tr_n <= {1'b0, tr_hi}) begin
               trail_we = 1'b1;
               d_in = d_ff + 1'b1;
               state_in = last_drop ? S_DONE : S_DROP;
            end
         end
         S_RD: begin
            mreq.addr = addr_ff;
            state_in = S_RDCAP;
         end
         S_RDCAP: begin
            value_in = rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!reply_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               reply_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      busy = (state_ff != S_IDLE);
      rsp.done = (state_ff == S_DONE) && reply_ff;
      rsp.op_done = (func_ff != FUNC_NONE);
      rsp.value = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         reply_ff <= 1'b0;
         cnt_ff <= '0;
         d_ff <= '0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
         cnt_ff <= cnt_in;
         d_ff <= d_in;
      end
      p_ff <= p_in;
      oth_ff <= oth_in;
      ch_ff <= ch_in;
      gfx_ff <= gfx_in;
      ret_glitch_ff <= ret_glitch_in;
      func_ff <= func_in;
      addr_ff <= addr_in;
      value_ff <= value_in;
      if (pos_we) drop_pos_ff[d_ff] <= pos_in;
      if (speed_we) drop_speed_ff[d_ff] <= speed_in;
      if (wait_we) drop_wait_ff[d_ff] <= wait_in;
      if (trail_we) drop_trail_ff[d_ff] <= trail_in;
   end
endmodule

// ----- rtl/falling_character_rain_engine_unit.sv -----
// Top level of the character-rain engine: ports, registers, result word.
`timescale 1ns / 1ps
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_func            | in word
//          | req_cell_address                        |
//  rsp     | rsp_valid rsp_stall rsp_cell_value      | out word
//          | rsp_op_done                             |
//  csr     | csr_write csr_index csr_data            | register write
// Read: S_RD addresses the store, S_RDCAP captures the byte, and S_DONE hands it to the
// registered rsp_valid. Init: store clear, then a speed and a trail are drawn per drop.
// Frame: walks the drops, plus redraws when a drop is recycled; at most one LFSR draw and one store access per cycle.
// After reset a store clear and init run with req stalled.
// Next word is taken while a result waits in the output register.
module falling_character_rain_engine_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [8:0] req_cell_address,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_cell_value,
   output logic       rsp_op_done,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
   import fcr_pkg::*;

   cfg_type     cfg_ff;
   seq_rsp_type srsp;
   logic        busy, rsp_free;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_value_ff;
   logic        rsp_done_ff;

   assign req_stall = busy;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   fcr_seq u_seq (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .start(req_valid && !busy), .func(req_func), .cell_address(req_cell_address),
      .rsp_free(rsp_free), .busy(busy), .rsp(srsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glitch_chance <= 8'd64;
         cfg_ff.reverse_chance <= 8'd64;
         cfg_ff.newchar_chance <= 8'd51;
         cfg_ff.graphic_chance <= 8'd16;
         cfg_ff.trail_min <= 5'd6;
         cfg_ff.trail_max <= 5'd14;
         cfg_ff.speed_start <= 6'd9;
         cfg_ff.speed_reset <= 6'd5;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_GLITCH:  cfg_ff.glitch_chance <= csr_data;
               REG_REVERSE: cfg_ff.reverse_chance <= csr_data;
               REG_NEWCHAR: cfg_ff.newchar_chance <= csr_data;
               REG_GRAPHIC: cfg_ff.graphic_chance <= csr_data;
               REG_TMIN:    cfg_ff.trail_min <= csr_data[4:0];
               REG_TMAX:    cfg_ff.trail_max <= csr_data[4:0];
               REG_SSTART:  cfg_ff.speed_start <= csr_data[5:0];
               REG_SRESET:  cfg_ff.speed_reset <= csr_data[5:0];
               default: ;
            endcase
         end
         if (srsp.done && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (srsp.done && rsp_free) begin
         rsp_value_ff <= srsp.value;
         rsp_done_ff <= srsp.op_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_op_done = rsp_done_ff;
endmodule
